>>> rtl/rtcg_pkg.sv
// Package for the radio time code generator: service codes, pulse widths,
// pipeline payload type and the BCD digit helpers. No dependencies.
`timescale 1ns / 1ps

package rtcg_pkg;

    typedef enum logic [1:0] {
        SVC_DCF77 = 2'd0,
        SVC_JJY   = 2'd1,
        SVC_MSF   = 2'd2,
        SVC_WWVB  = 2'd3
    } t_service;

    localparam int unsigned FRAME_W  = 60;
    localparam int unsigned PULSE_W  = 10;
    localparam int unsigned LAST_SEC = 59;

    localparam logic [PULSE_W-1:0] PW_0   = 10'd0;
    localparam logic [PULSE_W-1:0] PW_100 = 10'd100;
    localparam logic [PULSE_W-1:0] PW_200 = 10'd200;
    localparam logic [PULSE_W-1:0] PW_500 = 10'd500;
    localparam logic [PULSE_W-1:0] PW_800 = 10'd800;

    // reciprocal constants: x*205>>11 == x/10 for x < 1024,
    // x*5243>>19 == x/100 for x < 43690
    localparam logic [7:0]  RECIP10     = 8'd205;
    localparam int unsigned RECIP10_SH  = 11;
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int unsigned RECIP100_SH = 19;

    typedef struct packed {
        t_service    svc;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [2:0]  day_of_week;
        logic [3:0]  month;
        logic [13:0] full_year;
        logic [8:0]  day_of_year;
        logic        dst_now;
        logic        dst_tomorrow;
        logic [5:0]  second;
    } t_item;

    // three BCD digits {hundreds, tens, ones} of a value below 1000
    function automatic logic [11:0] f_bcd3(input logic [9:0] v);
        logic [17:0] p1;
        logic [6:0]  t;
        logic [14:0] p2;
        logic [3:0]  h;
        logic [9:0]  ones;
        logic [6:0]  tens;
        p1   = v * RECIP10;
        t    = p1[RECIP10_SH +: 7];
        p2   = t * RECIP10;
        h    = p2[RECIP10_SH +: 4];
        ones = v - 10'(t) * 10'd10;
        tens = t - 7'(h) * 7'd10;
        return {h, tens[3:0], ones[3:0]};
    endfunction

    // same digits with a zero bit between them
    function automatic logic [13:0] f_bcd3_pad(input logic [9:0] v);
        logic [11:0] d;
        d = f_bcd3(v);
        return {d[11:8], 1'b0, d[7:4], 1'b0, d[3:0]};
    endfunction

endpackage

>>> rtl/radio_time_code_generator_unit.sv
// Top level of the radio time code generator: four-stage pipeline that builds
// the 60-bit minute frame and the pulse width. Depends on rtcg_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive the time fields and i_second with start high; a
//   request is taken at every rising edge with start high and busy low. busy
//   stays low, so one request can be taken in every cycle.
//   Result channel: o_done is high for exactly one cycle with o_pulse_ms and
//   o_frame_bits; the receiver cannot stall, results are simply presented.
//   A request passes through the stages year divide by 100, year digits and
//   leap flag, digit placement, and parity and pulse select before o_done.
//   Throughput is one result per cycle.
//   Config channel: i_cfg_valid / o_cfg_ready / i_cfg_data set the service
//   (0 DCF77, 1 JJY, 2 MSF, 3 WWVB); o_cfg_ready is always high. The service
//   is sampled with each request and travels with it.
//   Reset (synchronous, active low) empties the pipeline and selects DCF77.
module radio_time_code_generator_unit
    import rtcg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [5:0]          i_minute,
    input  logic [4:0]          i_hour,
    input  logic [4:0]          i_day_of_month,
    input  logic [2:0]          i_day_of_week,
    input  logic [3:0]          i_month,
    input  logic [13:0]         i_full_year,
    input  logic [8:0]          i_day_of_year,
    input  logic                i_dst_now,
    input  logic                i_dst_tomorrow,
    input  logic [5:0]          i_second,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_data,
    output logic                o_done,
    output logic [PULSE_W-1:0]  o_pulse_ms,
    output logic [FRAME_W-1:0]  o_frame_bits
);

    t_service r_service;

    logic               r_s1_valid, r_s2_valid, r_s3_valid, r_done;
    t_item              r_s1_item, r_s2_item;
    logic [7:0]         r_s1_q;
    logic [6:0]         r_s2_yy;
    logic               r_s2_leap;
    t_service           r_s3_svc;
    logic [5:0]         r_s3_sec;
    logic [FRAME_W-1:0] r_s3_frame;
    logic [PULSE_W-1:0] r_pulse;
    logic [FRAME_W-1:0] r_frame;

    logic               n_accept;
    t_item              n_item;
    logic [26:0]        n_q_prod;
    logic [13:0]        n_yy_full;
    logic               n_leap;
    logic [FRAME_W-1:0] n_raw;
    logic [FRAME_W-1:0] n_frame;
    logic [PULSE_W-1:0] n_pulse;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign n_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service <= SVC_DCF77;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_service <= t_service'(i_cfg_data);
        end
    end

    // stage 1: year / 100
    always_comb begin
        n_item.svc          = r_service;
        n_item.minute       = i_minute;
        n_item.hour         = i_hour;
        n_item.day_of_month = i_day_of_month;
        n_item.day_of_week  = i_day_of_week;
        n_item.month        = i_month;
        n_item.full_year    = i_full_year;
        n_item.day_of_year  = i_day_of_year;
        n_item.dst_now      = i_dst_now;
        n_item.dst_tomorrow = i_dst_tomorrow;
        n_item.second       = i_second;
        n_q_prod            = i_full_year * RECIP100;
    end

    // stage 2: year mod 100 and Gregorian leap flag
    always_comb begin
        n_yy_full = r_s1_item.full_year - 14'(r_s1_q) * 14'd100;
        n_leap    = (r_s1_item.full_year[1:0] == 2'b00)
                    && ((n_yy_full != 14'd0) || (r_s1_q[1:0] == 2'b00));
    end

    // stage 3: digit placement per service
    always_comb begin
        logic [11:0] d_mi, d_hr, d_md, d_wd, d_wd7, d_mo, d_yy, d_yd;
        logic [13:0] p_mi, p_hr, p_yd, p_yy;
        d_mi  = f_bcd3(10'(r_s2_item.minute));
        d_hr  = f_bcd3(10'(r_s2_item.hour));
        d_md  = f_bcd3(10'(r_s2_item.day_of_month));
        d_wd  = f_bcd3(10'(r_s2_item.day_of_week));
        d_wd7 = (r_s2_item.day_of_week == 3'd0) ? 12'd7 : d_wd;
        d_mo  = f_bcd3(10'(r_s2_item.month));
        d_yy  = f_bcd3(10'(r_s2_yy));
        d_yd  = f_bcd3(10'(r_s2_item.day_of_year));
        p_mi  = f_bcd3_pad(10'(r_s2_item.minute));
        p_hr  = f_bcd3_pad(10'(r_s2_item.hour));
        p_yd  = f_bcd3_pad(10'(r_s2_item.day_of_year));
        p_yy  = f_bcd3_pad(10'(r_s2_yy));
        n_raw = '0;
        case (r_s2_item.svc)
            SVC_DCF77: begin
                n_raw = (FRAME_W'(r_s2_item.dst_now) << 17)
                      | (FRAME_W'(!r_s2_item.dst_now) << 18)
                      | (FRAME_W'(1) << 20)
                      | (FRAME_W'(d_mi) << 21)
                      | (FRAME_W'(d_hr) << 29)
                      | (FRAME_W'(d_md) << 36)
                      | (FRAME_W'(d_wd7) << 42)
                      | (FRAME_W'(d_mo) << 45)
                      | (FRAME_W'(d_yy) << 50);
            end
            SVC_JJY: begin
                n_raw = (FRAME_W'(p_mi) << 51)
                      | (FRAME_W'(p_hr) << 41)
                      | (FRAME_W'(p_yd) << 26)
                      | (FRAME_W'(d_yy) << 11)
                      | (FRAME_W'(d_wd) << 7);
            end
            SVC_MSF: begin
                n_raw = (FRAME_W'(d_yy) << 35)
                      | (FRAME_W'(d_mo) << 30)
                      | (FRAME_W'(d_md) << 24)
                      | (FRAME_W'(d_wd) << 21)
                      | (FRAME_W'(d_hr) << 15)
                      | (FRAME_W'(d_mi) << 8)
                      | (FRAME_W'(r_s2_item.dst_now) << 1);
            end
            SVC_WWVB: begin
                n_raw = (FRAME_W'(p_mi) << 51)
                      | (FRAME_W'(p_hr) << 41)
                      | (FRAME_W'(p_yd) << 26)
                      | (FRAME_W'(p_yy) << 6)
                      | (FRAME_W'(r_s2_leap) << 4)
                      | (FRAME_W'(r_s2_item.dst_tomorrow) << 2)
                      | (FRAME_W'(r_s2_item.dst_now) << 1);
            end
            default: n_raw = '0;
        endcase
    end

    // stage 4: parity bits and pulse width
    always_comb begin
        logic       sec_hi, marker, bit_v;
        logic [5:0] idx;
        n_frame = r_s3_frame;
        case (r_s3_svc)
            SVC_DCF77: begin
                n_frame[28] = n_frame[28] | (^r_s3_frame[27:21]);
                n_frame[35] = n_frame[35] | (^r_s3_frame[34:29]);
                n_frame[58] = n_frame[58] | (^r_s3_frame[57:36]);
            end
            SVC_JJY: begin
                n_frame[23] = n_frame[23] | (^r_s3_frame[47:41]);
                n_frame[22] = n_frame[22] | (^r_s3_frame[58:51]);
            end
            SVC_MSF: begin
                n_frame[5] = n_frame[5] | ~(^r_s3_frame[42:35]);
                n_frame[4] = n_frame[4] | ~(^r_s3_frame[34:24]);
                n_frame[3] = n_frame[3] | ~(^r_s3_frame[23:21]);
                n_frame[2] = n_frame[2] | ~(^r_s3_frame[20:8]);
            end
            default: n_frame = r_s3_frame;
        endcase

        sec_hi = r_s3_sec > 6'(LAST_SEC);
        marker = (r_s3_sec == 6'd0) || (r_s3_sec == 6'd9) || (r_s3_sec == 6'd19)
                 || (r_s3_sec == 6'd29) || (r_s3_sec == 6'd39)
                 || (r_s3_sec == 6'd49) || (r_s3_sec == 6'd59) || sec_hi;
        if (r_s3_svc == SVC_DCF77) begin
            idx = (r_s3_sec >= 6'(LAST_SEC)) ? 6'd0 : r_s3_sec;
        end else begin
            idx = sec_hi ? 6'd0 : 6'(LAST_SEC) - r_s3_sec;
        end
        bit_v = n_frame[idx];

        case (r_s3_svc)
            SVC_DCF77: begin
                if (r_s3_sec >= 6'(LAST_SEC)) n_pulse = PW_0;
                else n_pulse = bit_v ? PW_200 : PW_100;
            end
            SVC_JJY: begin
                if (marker) n_pulse = PW_200;
                else n_pulse = bit_v ? PW_500 : PW_800;
            end
            SVC_MSF: begin
                if (r_s3_sec == 6'd0 || sec_hi) begin
                    n_pulse = PW_500;
                end else begin
                    n_pulse = PW_100 + (bit_v ? PW_100 : PW_0)
                            + ((r_s3_sec > 6'd52 && r_s3_sec < 6'(LAST_SEC)) ? PW_100 : PW_0);
                end
            end
            SVC_WWVB: begin
                if (marker) n_pulse = PW_800;
                else n_pulse = bit_v ? PW_500 : PW_200;
            end
            default: n_pulse = PW_0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= n_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_done     <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item  <= n_item;
        r_s1_q     <= n_q_prod[RECIP100_SH +: 8];
        r_s2_item  <= r_s1_item;
        r_s2_yy    <= n_yy_full[6:0];
        r_s2_leap  <= n_leap;
        r_s3_svc   <= r_s2_item.svc;
        r_s3_sec   <= r_s2_item.second;
        r_s3_frame <= n_raw;
        r_pulse    <= n_pulse;
        r_frame    <= n_frame;
    end

    assign o_done       = r_done;
    assign o_pulse_ms   = r_pulse;
    assign o_frame_bits = r_frame;

endmodule

>>> rtl/rtcg_checker.sv
// Port-level checker for the radio time code generator and its bind.
// Depends on rtcg_pkg and radio_time_code_generator_unit.
`timescale 1ns / 1ps

module rtcg_checker
    import rtcg_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic [PULSE_W-1:0] o_pulse_ms
);

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("request without result after 4 cycles");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##4 !o_done)
        else $error("result without request");

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pulse_ms <= PW_800))
        else $error("pulse width out of range");

endmodule

bind radio_time_code_generator_unit rtcg_checker u_rtcg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_done     (o_done),
    .o_pulse_ms (o_pulse_ms)
);
